/* rtl/ppph_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the parallel port packet handshake engine.
// No dependencies; used by the sequencer and the top level.

package ppph_pkg;

    // default packet buffer depth
    localparam int PACKET_DEPTH_DEF = 256;

    // configuration register indexes and reset values
    localparam logic REG_TIMEOUT     = 1'b0;
    localparam logic REG_SHORT_DELAY = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd2000;
    localparam logic [7:0]  SHORT_DELAY_RESET = 8'd2;

    // input item kinds
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // control line values
    localparam logic [5:0] CTL_IDLE      = 6'h06;
    localparam logic [5:0] CTL_STROBE_LO = 6'h04;
    localparam logic [5:0] CTL_STROBE_HI = 6'h05;
    localparam logic [5:0] CTL_REV_SETUP = 6'h26;
    localparam logic [5:0] CTL_REV_REQ   = 6'h22;
    localparam logic [5:0] CTL_REV_ACK   = 6'h20;

    // status patterns
    localparam logic [7:0] ST_MASK     = 8'hf8;
    localparam logic [7:0] ST_ACK_A    = 8'h78;
    localparam logic [7:0] ST_ACK_B    = 8'hf0;
    localparam logic [7:0] ST_REPLY    = 8'h10;
    localparam logic [7:0] ST_NIB_MASK = 8'hf7;
    localparam logic [7:0] ST_NIB_WANT = 8'h50;
    localparam logic [7:0] ST_END      = 8'h58;
    localparam logic [7:0] ST_QUIET    = 8'hf8;

    // one result item
    typedef struct packed {
        logic       failed;
        logic       done_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic [7:0] data_out;
        logic [5:0] control_out;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

/* rtl/ppph_seq.sv */
`timescale 1ns / 1ps
// Handshake sequencer with the packet buffer memory.
// Depends on ppph_pkg; produces one result per accepted item.

module ppph_seq #(
    parameter int PACKET_DEPTH = ppph_pkg::PACKET_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_fire,
    input  logic [1:0]           action,
    input  logic [7:0]           status_lines,
    input  logic [7:0]           data_lines,
    input  logic [7:0]           send_byte,
    input  logic [7:0]           max_read,
    input  logic [15:0]          timeout_ticks,
    input  logic [7:0]           short_delay_ticks,
    output ppph_pkg::result_t    res
);

    localparam int AW  = $clog2(PACKET_DEPTH);
    localparam int CAP = (PACKET_DEPTH < 255) ? PACKET_DEPTH : 255;
    localparam logic [7:0] CAP_B = CAP[7:0];

    // phase codes
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_DLY_A = 4'd1;
    localparam logic [3:0] PH_DLY_B = 4'd2;
    localparam logic [3:0] PH_W78   = 4'd3;
    localparam logic [3:0] PH_WF0   = 4'd4;
    localparam logic [3:0] PH_DLY_R = 4'd5;
    localparam logic [3:0] PH_W10   = 4'd6;
    localparam logic [3:0] PH_W50   = 4'd7;
    localparam logic [3:0] PH_W58   = 4'd8;
    localparam logic [3:0] PH_WF8   = 4'd9;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  loaded_reg, loaded_next;
    logic [7:0]  send_idx_reg, send_idx_next;
    logic [7:0]  recv_reg, recv_next;
    logic [7:0]  limit_reg, limit_next;
    logic [7:0]  third_reg, third_next;
    logic [15:0] wait_reg, wait_next;
    logic [5:0]  ctl_reg, ctl_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  first_reg;

    // packet buffer, one write and one registered read port
    logic [7:0]    store_mem [PACKET_DEPTH];
    logic [7:0]    rd_q;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    logic [15:0] wait_inc;
    logic [7:0]  st;
    logic [7:0]  idx_inc;
    logic [7:0]  recv_inc;
    logic        delay_over;
    logic        wait_expired;
    logic        rvalid, done, fail;
    logic [7:0]  rbyte;

    function automatic logic [7:0] loaded_inc(input logic [7:0] cnt);
        loaded_inc = cnt + 8'd1;
    endfunction

    assign st           = status_lines & ppph_pkg::ST_MASK;
    assign wait_inc     = wait_reg + 16'd1;
    assign wait_expired = (wait_inc >= timeout_ticks);
    assign delay_over   = (wait_reg >= {8'd0, short_delay_ticks});
    assign idx_inc      = send_idx_reg + 8'd1;
    assign recv_inc     = recv_reg + 8'd1;
    assign wr_en        = item_fire && (phase_reg == PH_IDLE)
                          && (action == ppph_pkg::ACT_LOAD) && (loaded_reg < CAP_B);

    // next-state logic for one item
    always_comb
    begin
        phase_next    = phase_reg;
        loaded_next   = loaded_reg;
        send_idx_next = send_idx_reg;
        recv_next     = recv_reg;
        limit_next    = limit_reg;
        third_next    = third_reg;
        wait_next     = wait_reg;
        ctl_next      = ctl_reg;
        data_next     = data_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        rvalid        = 1'b0;
        rbyte         = 8'd0;
        done          = 1'b0;
        fail          = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (action == ppph_pkg::ACT_LOAD)
            begin
                if (loaded_reg < CAP_B)
                    loaded_next = loaded_inc(loaded_reg);
            end
            else if (action == ppph_pkg::ACT_START)
            begin
                recv_next     = 8'd0;
                third_next    = 8'd0;
                limit_next    = max_read;
                send_idx_next = 8'd0;
                if (loaded_reg == 8'd0)
                    done = 1'b1;
                else
                begin
                    // first byte is held aside, prefetch the second
                    data_next  = first_reg;
                    phase_next = PH_DLY_A;
                    ctl_next   = ppph_pkg::CTL_IDLE;
                    wait_next  = 16'd0;
                    rd_en      = 1'b1;
                    rd_addr    = AW'(8'd1);
                end
            end
        end
        else if (action == ppph_pkg::ACT_TICK)
        begin
            unique case (phase_reg)
                PH_DLY_A, PH_DLY_B, PH_DLY_R:
                begin
                    if (delay_over)
                    begin
                        wait_next = 16'd0;
                        if (phase_reg == PH_DLY_A)
                        begin
                            phase_next = PH_DLY_B;
                            ctl_next   = ppph_pkg::CTL_STROBE_LO;
                        end
                        else if (phase_reg == PH_DLY_B)
                        begin
                            phase_next = PH_W78;
                            ctl_next   = ppph_pkg::CTL_STROBE_HI;
                        end
                        else
                        begin
                            phase_next = PH_W10;
                            ctl_next   = ppph_pkg::CTL_REV_REQ;
                        end
                    end
                    else
                        wait_next = wait_inc;
                end
                PH_W78:
                begin
                    if (st == ppph_pkg::ST_ACK_A)
                    begin
                        phase_next = PH_WF0;
                        ctl_next   = ppph_pkg::CTL_STROBE_LO;
                        wait_next  = 16'd0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        fail      = wait_expired;
                    end
                end
                PH_WF0:
                begin
                    if (st == ppph_pkg::ST_ACK_B)
                    begin
                        send_idx_next = idx_inc;
                        wait_next     = 16'd0;
                        if (idx_inc >= loaded_reg)
                        begin
                            if (limit_reg == 8'd0)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_DLY_R;
                                ctl_next   = ppph_pkg::CTL_REV_SETUP;
                            end
                        end
                        else
                        begin
                            // prefetched byte goes out, fetch the one after
                            data_next  = rd_q;
                            phase_next = PH_DLY_A;
                            rd_en      = 1'b1;
                            rd_addr    = AW'(idx_inc + 8'd1);
                        end
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        fail      = wait_expired;
                    end
                end
                PH_W10:
                begin
                    if (st == ppph_pkg::ST_REPLY)
                    begin
                        rvalid    = 1'b1;
                        rbyte     = data_lines;
                        recv_next = recv_inc;
                        if (recv_inc == 8'd3)
                            third_next = data_lines;
                        if (recv_inc == 8'd4)
                            limit_next = third_reg;
                        phase_next = PH_W50;
                        ctl_next   = ppph_pkg::CTL_REV_ACK;
                        wait_next  = 16'd0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        fail      = wait_expired;
                    end
                end
                PH_W50:
                begin
                    if ((st & ppph_pkg::ST_NIB_MASK) == ppph_pkg::ST_NIB_WANT)
                    begin
                        ctl_next  = ppph_pkg::CTL_REV_REQ;
                        wait_next = 16'd0;
                        if (st != ppph_pkg::ST_END && recv_reg < limit_reg)
                            phase_next = PH_W10;
                        else
                            phase_next = PH_W58;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        fail      = wait_expired;
                    end
                end
                PH_W58:
                begin
                    if (st == ppph_pkg::ST_END)
                    begin
                        phase_next = PH_WF8;
                        ctl_next   = ppph_pkg::CTL_REV_SETUP;
                        wait_next  = 16'd0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        fail      = wait_expired;
                    end
                end
                PH_WF8:
                begin
                    if (st == ppph_pkg::ST_QUIET)
                    begin
                        phase_next = PH_IDLE;
                        ctl_next   = ppph_pkg::CTL_IDLE;
                        wait_next  = 16'd0;
                        done       = 1'b1;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        fail      = wait_expired;
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        // timeout ends the exchange, lines keep their values
        if (fail)
        begin
            done       = 1'b1;
            phase_next = PH_IDLE;
            wait_next  = 16'd0;
        end
        if (done)
            loaded_next = 8'd0;

        res.control_out = ctl_next;
        res.data_out    = data_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.read_valid  = rvalid;
        res.read_byte   = rbyte;
        res.done_res    = done;
        res.failed      = fail;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            loaded_reg   <= 8'd0;
            send_idx_reg <= 8'd0;
            recv_reg     <= 8'd0;
            limit_reg    <= 8'd0;
            third_reg    <= 8'd0;
            wait_reg     <= 16'd0;
            ctl_reg      <= ppph_pkg::CTL_IDLE;
            data_reg     <= 8'd0;
        end
        else if (item_fire)
        begin
            phase_reg    <= phase_next;
            loaded_reg   <= loaded_next;
            send_idx_reg <= send_idx_next;
            recv_reg     <= recv_next;
            limit_reg    <= limit_next;
            third_reg    <= third_next;
            wait_reg     <= wait_next;
            ctl_reg      <= ctl_next;
            data_reg     <= data_next;
        end
    end

    // packet buffer write, first byte also kept in a register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[loaded_reg[AW-1:0]] <= send_byte;
            if (loaded_reg == 8'd0)
                first_reg <= send_byte;
        end
    end

    // packet buffer read, registered output
    always_ff @(posedge clk)
    begin
        if (item_fire && rd_en)
            rd_q <= store_mem[rd_addr];
    end

endmodule

/* rtl/parallel_port_packet_handshake.sv */
`timescale 1ns / 1ps
// Top level of the parallel port packet handshake engine: stream ports,
// configuration registers and output skid stage. Uses ppph_pkg, ppph_seq.
//
// channel   direction  accepted when          content
// s_*       in         s_tvalid & s_tready    port sample, load byte or start
// m_*       out        m_tvalid & m_tready    line values, reply byte, done
// cfg_*     in         cfg_valid & cfg_ready  timeout and short delay
//
// Every item gives one result; items are taken every cycle while s_tready is
// high; each result is registered on m_tdata, or in the skid stage on a stall.
// The packet buffer is read one byte ahead, so its registered read latency is
// hidden. Reset clears the sequencer and restores the register defaults.
// A stalled output holds one result and parks one more in the skid stage;
// s_tready falls only while the skid stage is full.

module parallel_port_packet_handshake #(
    parameter int PACKET_DEPTH = ppph_pkg::PACKET_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // status_lines, data_lines, send_byte, max_read
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    // control_out, data_out, busy_res, read_valid, read_byte, done_res, failed
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic               item_fire;
    logic [15:0]        timeout_reg;
    logic [7:0]         short_delay_reg;
    ppph_pkg::result_t  res;
    ppph_pkg::result_t  out_reg;
    ppph_pkg::result_t  skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    assign s_tready  = !skid_valid_reg;
    assign item_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= ppph_pkg::TIMEOUT_RESET;
            short_delay_reg <= ppph_pkg::SHORT_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ppph_pkg::REG_TIMEOUT:     timeout_reg     <= cfg_data;
                ppph_pkg::REG_SHORT_DELAY: short_delay_reg <= cfg_data[7:0];
                default:                   timeout_reg     <= timeout_reg;
            endcase
        end
    end

    ppph_seq #(
        .PACKET_DEPTH(PACKET_DEPTH)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_fire         (item_fire),
        .action            (s_tuser),
        .status_lines      (s_tdata[7:0]),
        .data_lines        (s_tdata[15:8]),
        .send_byte         (s_tdata[23:16]),
        .max_read          (s_tdata[31:24]),
        .timeout_ticks     (timeout_reg),
        .short_delay_ticks (short_delay_reg),
        .res               (res)
    );

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= item_fire;
        end
        else if (item_fire)
            skid_valid_reg <= 1'b1;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (item_fire)
                out_reg <= res;
        end
        else if (item_fire)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32 - ppph_pkg::RESULT_W){1'b0}}, out_reg};

endmodule

/* rtl/ppph_check.sv */
`timescale 1ns / 1ps
// Port-level checker for the parallel port packet handshake engine.
// Depends on nothing but the top level's ports; bound to the top level below.

module ppph_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    // a stalled result stays and holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input is refused only after the output stalled
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input refused without an output stall");

    // failure comes only with done, and done leaves the engine idle
    a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25] || m_tdata[24]) |-> m_tdata[24] && !m_tdata[14])
        else $error("failed without done, or busy after done");

    // a reply byte is captured only inside an exchange
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[14] && !m_tdata[24])
        else $error("reply byte outside an exchange");

endmodule

bind parallel_port_packet_handshake ppph_check u_ppph_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
